// ----- rtl/ikm_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and helper functions of the ikeda map iterator
package ikm_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int ANG_FRAC     = 60;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CNT_W        = $clog2(WORD_BITS) + 1;
  // quotient of |theta| by two pi stays below 2^MOD_STEPS
  localparam int MOD_STEPS    = 5;
  localparam int MOD_SH_W     = $clog2(MOD_STEPS);
  localparam int CFG_W        = 2;

  localparam logic signed [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [WORD_BITS-1:0] ONEV = WORD_BITS'(1) << FRAC_BITS;

  localparam logic [63:0]        PI61    = 64'h6487ED5110B4611A;
  localparam logic signed [63:0] PI60    = signed'(PI61 >> 1);
  localparam logic signed [63:0] HALF_PI = signed'(PI61 >> 2);
  localparam logic signed [63:0] KGAIN60 = 64'sd700114967507363826;
  localparam logic [WORD_BITS-1:0] TWO_PI = WORD_BITS'(PI61 >> (ANG_FRAC - FRAC_BITS));

  localparam logic signed [WORD_BITS-1:0] A_RST = 32'sd14260634;
  localparam logic signed [WORD_BITS-1:0] B_RST = 32'sd15099494;
  localparam logic signed [WORD_BITS-1:0] K_RST = 32'sd6710886;
  localparam logic signed [WORD_BITS-1:0] P_RST = 32'sd129184563;

  localparam logic [CFG_W-1:0] CFG_OFFSET_A = 2'd0;
  localparam logic [CFG_W-1:0] CFG_GAIN_B   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_PHASE_K  = 2'd2;
  localparam logic [CFG_W-1:0] CFG_PHASE_P  = 2'd3;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        sat;
  } sres_t;

  typedef logic [CORDIC_STEPS-1:0][63:0] atan_tbl_t;

  // clip a widened sum to the word limits
  function automatic sres_t clip(input logic signed [WORD_BITS+1:0] v);
    sres_t r;
    if (v > (WORD_BITS+2)'(MAXV)) begin
      r.val = MAXV;
      r.sat = 1'b1;
    end else if (v < (WORD_BITS+2)'(MINV)) begin
      r.val = MINV;
      r.sat = 1'b1;
    end else begin
      r.val = WORD_BITS'(v);
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [63:0] atan_term(input int i, input int n);
    if (i * n > ANG_FRAC) return '0;
    return 64'd1 << (ANG_FRAC - i * n);
  endfunction

  // atan(2^-i) at 60 fraction bits: pi/4 for i of zero, else the truncated taylor series
  function automatic atan_tbl_t atan_table();
    atan_tbl_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        t[i] = PI61 >> 3;
      end else begin
        t[i] = atan_term(i, 1) - atan_term(i, 3) / 3 + atan_term(i, 5) / 5
             - atan_term(i, 7) / 7 + atan_term(i, 9) / 9 - atan_term(i, 11) / 11
             + atan_term(i, 13) / 13 - atan_term(i, 15) / 15 + atan_term(i, 17) / 17
             - atan_term(i, 19) / 19 + atan_term(i, 21) / 21 - atan_term(i, 23) / 23
             + atan_term(i, 25) / 25 - atan_term(i, 27) / 27 + atan_term(i, 29) / 29
             - atan_term(i, 31) / 31 + atan_term(i, 33) / 33 - atan_term(i, 35) / 35
             + atan_term(i, 37) / 37 - atan_term(i, 39) / 39 + atan_term(i, 41) / 41
             - atan_term(i, 43) / 43 + atan_term(i, 45) / 45 - atan_term(i, 47) / 47
             + atan_term(i, 49) / 49 - atan_term(i, 51) / 51 + atan_term(i, 53) / 53
             - atan_term(i, 55) / 55 + atan_term(i, 57) / 57 - atan_term(i, 59) / 59;
      end
    end
    return t;
  endfunction

endpackage

// ----- rtl/ikm_qmul.sv -----
`timescale 1ns / 1ps
// registered saturating fixed-point multiplier, truncating toward zero
module ikm_qmul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [ikm_pkg::WORD_BITS-1:0] a_i,
  input  logic signed [ikm_pkg::WORD_BITS-1:0] b_i,
  output logic signed [ikm_pkg::WORD_BITS-1:0] p_o,
  output logic                                sat_o,
  output logic                                vld_o
);
  import ikm_pkg::*;

  logic                        neg;
  logic [WORD_BITS-1:0]        ua, ub;
  logic [2*WORD_BITS-1:0]      prod;
  logic [2*WORD_BITS-FRAC_BITS-1:0] rlo, limit;
  logic signed [WORD_BITS-1:0] p_d, p_q;
  logic                        sat_d, sat_q, vld_q;

  always_comb begin
    neg   = a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
    ua    = a_i[WORD_BITS-1] ? WORD_BITS'(-a_i) : WORD_BITS'(a_i);
    ub    = b_i[WORD_BITS-1] ? WORD_BITS'(-b_i) : WORD_BITS'(b_i);
    prod  = (2*WORD_BITS)'(ua) * (2*WORD_BITS)'(ub);
    rlo   = prod[2*WORD_BITS-1:FRAC_BITS];
    limit = neg ? (2*WORD_BITS-FRAC_BITS)'(MAXV) + 1'b1
                : (2*WORD_BITS-FRAC_BITS)'(MAXV);
    sat_d = rlo > limit;
    if (sat_d) begin
      p_d = neg ? MINV : MAXV;
    end else begin
      p_d = neg ? -signed'(rlo[WORD_BITS-1:0]) : signed'(rlo[WORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= en_i;
    end
  end

  assign p_o   = p_q;
  assign sat_o = sat_q;
  assign vld_o = vld_q;

endmodule

// ----- rtl/ikeda_map_iterator.sv -----
`timescale 1ns / 1ps
// ikeda map iterator: sequencer with shared multiplier, divider and cordic
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  input     | in_valid_i / in_ready_o    | restart_i
//  output    | out_valid_o / out_ready_i  | z_real_o, z_imag_o, saturated_o
//  config    | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// one item takes 32 divider steps for p/(1+|z|^2), 24 cordic steps and eight
// passes through the single 32x32 multiplier.
// in_ready_o is high only while the sequencer is idle; a finished result sits
// in the output register, and a further result waits in the last step until it
// is taken. reset loads the default constants and clears z.
module ikeda_map_iterator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ikm_pkg::WORD_BITS-1:0] z_real_o,
  output logic signed [ikm_pkg::WORD_BITS-1:0] z_imag_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_we_i,
  input  logic [ikm_pkg::CFG_W-1:0]            cfg_idx_i,
  input  logic [ikm_pkg::WORD_BITS-1:0]        cfg_data_i
);
  import ikm_pkg::*;

  localparam atan_tbl_t ATAN_TBL = atan_table();
  localparam int SHIFT_DN = ANG_FRAC - FRAC_BITS;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_SQX   = 18'h00002,
    S_SQY   = 18'h00004,
    S_DEN   = 18'h00008,
    S_DIV   = 18'h00010,
    S_THETA = 18'h00020,
    S_MOD   = 18'h00040,
    S_WRAP  = 18'h00080,
    S_FOLD  = 18'h00100,
    S_ROT   = 18'h00200,
    S_SC    = 18'h00400,
    S_M1    = 18'h00800,
    S_M2    = 18'h01000,
    S_M3    = 18'h02000,
    S_M4    = 18'h04000,
    S_M5    = 18'h08000,
    S_M6    = 18'h10000,
    S_DONE  = 18'h20000
  } state_e;

  state_e state_d, state_q;

  logic signed [WORD_BITS-1:0] a_q, b_q, k_q, p_q;
  logic signed [WORD_BITS-1:0] x_d, x_q, y_d, y_q;
  logic signed [WORD_BITS-1:0] acc_d, acc_q;
  logic [WORD_BITS-1:0]        den_d, den_q, rem_d, rem_q, dv_d, dv_q, quo_d, quo_q;
  logic [WORD_BITS-1:0]        r_d, r_q;
  logic                        thneg_d, thneg_q, flip_d, flip_q;
  logic [CNT_W-1:0]            cnt_d, cnt_q;
  logic signed [63:0]          ang_d, ang_q, cx_d, cx_q, cy_d, cy_q;
  logic signed [WORD_BITS-1:0] c_d, c_q, s_d, s_q;
  logic signed [WORD_BITS-1:0] wr_d, wr_q, wi_d, wi_q, nr_d, nr_q;
  logic                        sat_d, sat_q;
  logic                        ov_d, ov_q;
  logic signed [WORD_BITS-1:0] zr_d, zr_q, zi_d, zi_q;
  logic                        zs_d, zs_q;

  logic                        mul_en, mul_sat, mul_vld;
  logic signed [WORD_BITS-1:0] mul_a, mul_b, mul_p;

  sres_t                       s1, s2;
  logic [WORD_BITS-1:0]        pmag, tmag, rr, msub;
  logic [WORD_BITS:0]          trial;
  logic signed [WORD_BITS:0]   qs;
  logic [STEP_W-1:0]           step;
  logic signed [63:0]          dx, dy, tv, cs, ss;

  ikm_qmul u_qmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .p_o    (mul_p),
    .sat_o  (mul_sat),
    .vld_o  (mul_vld)
  );

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = x_q;
    mul_b  = x_q;
    case (state_q)
      S_SQX: begin mul_a = x_q; mul_b = x_q; end
      S_SQY: begin mul_a = y_q; mul_b = y_q; end
      S_M1:  begin mul_a = x_q; mul_b = c_q; end
      S_M2:  begin mul_a = y_q; mul_b = s_q; end
      S_M3:  begin mul_a = x_q; mul_b = s_q; end
      S_M4:  begin mul_a = y_q; mul_b = c_q; end
      S_M5:  begin mul_a = b_q; mul_b = wr_q; end
      S_M6:  begin mul_a = b_q; mul_b = wi_q; end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    x_d = x_q;   y_d = y_q;   acc_d = acc_q;
    den_d = den_q; rem_d = rem_q; dv_d = dv_q; quo_d = quo_q;
    r_d = r_q;   thneg_d = thneg_q; flip_d = flip_q; cnt_d = cnt_q;
    ang_d = ang_q; cx_d = cx_q; cy_d = cy_q;
    c_d = c_q;   s_d = s_q;   wr_d = wr_q; wi_d = wi_q; nr_d = nr_q;
    ov_d = ov_q; zr_d = zr_q; zi_d = zi_q; zs_d = zs_q;
    sat_d = sat_q | (mul_vld & mul_sat);

    s1    = clip((WORD_BITS+2)'(acc_q) + (WORD_BITS+2)'(mul_p));
    s2    = clip((WORD_BITS+2)'(ONEV) + (WORD_BITS+2)'(s1.val));
    pmag  = p_q[WORD_BITS-1] ? WORD_BITS'(-p_q) : WORD_BITS'(p_q);
    trial = {rem_q, dv_q[WORD_BITS-1]};
    qs    = p_q[WORD_BITS-1] ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
    tmag  = '0;
    msub  = TWO_PI << cnt_q[MOD_SH_W-1:0];
    rr    = (thneg_q && r_q != '0) ? TWO_PI - r_q : r_q;
    step  = cnt_q[STEP_W-1:0];
    dx    = cy_q >>> step;
    dy    = cx_q >>> step;
    tv    = signed'(ATAN_TBL[step]);
    cs    = cx_q >>> SHIFT_DN;
    ss    = cy_q >>> SHIFT_DN;

    if (out_valid_o && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sat_d = 1'b0;
          if (restart_i) begin
            x_d = '0;
            y_d = '0;
          end
          state_d = S_SQX;
        end
      end
      S_SQX: state_d = S_SQY;
      S_SQY: begin
        acc_d   = mul_p;
        state_d = S_DEN;
      end
      S_DEN: begin
        // d = 1 + |z|^2, never below one
        sat_d   = sat_d | s1.sat | s2.sat;
        den_d   = WORD_BITS'(s2.val);
        rem_d   = pmag >> (WORD_BITS - FRAC_BITS);
        dv_d    = pmag << FRAC_BITS;
        quo_d   = '0;
        cnt_d   = CNT_W'(WORD_BITS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = WORD_BITS'(trial - {1'b0, den_q});
          quo_d = {quo_q[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_d = trial[WORD_BITS-1:0];
          quo_d = {quo_q[WORD_BITS-2:0], 1'b0};
        end
        dv_d = dv_q << 1;
        if (cnt_q == '0) begin
          state_d = S_THETA;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_THETA: begin
        s1      = clip((WORD_BITS+2)'(k_q) - (WORD_BITS+2)'(qs));
        sat_d   = sat_d | s1.sat;
        thneg_d = s1.val[WORD_BITS-1];
        tmag    = s1.val[WORD_BITS-1] ? WORD_BITS'(-s1.val) : WORD_BITS'(s1.val);
        r_d     = tmag;
        cnt_d   = CNT_W'(MOD_STEPS - 1);
        state_d = S_MOD;
      end
      S_MOD: begin
        // restoring reduction modulo two pi
        if (r_q >= msub) begin
          r_d = r_q - msub;
        end
        if (cnt_q == '0) begin
          state_d = S_WRAP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_WRAP: begin
        ang_d = signed'(64'(rr) << SHIFT_DN);
        if (ang_d > PI60) begin
          ang_d = ang_d - 2 * PI60;
        end
        state_d = S_FOLD;
      end
      S_FOLD: begin
        // fold into the right half plane, negating cos and sin later
        flip_d = 1'b0;
        if (ang_q > HALF_PI) begin
          ang_d  = ang_q - PI60;
          flip_d = 1'b1;
        end else if (ang_q < -HALF_PI) begin
          ang_d  = ang_q + PI60;
          flip_d = 1'b1;
        end
        cx_d    = KGAIN60;
        cy_d    = '0;
        cnt_d   = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        if (ang_q >= 0) begin
          cx_d  = cx_q - dx;
          cy_d  = cy_q + dy;
          ang_d = ang_q - tv;
        end else begin
          cx_d  = cx_q + dx;
          cy_d  = cy_q - dy;
          ang_d = ang_q + tv;
        end
        if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = S_SC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SC: begin
        c_d     = flip_q ? -WORD_BITS'(cs) : WORD_BITS'(cs);
        s_d     = flip_q ? -WORD_BITS'(ss) : WORD_BITS'(ss);
        state_d = S_M1;
      end
      S_M1: state_d = S_M2;
      S_M2: begin
        acc_d   = mul_p;
        state_d = S_M3;
      end
      S_M3: begin
        s1      = clip((WORD_BITS+2)'(acc_q) - (WORD_BITS+2)'(mul_p));
        sat_d   = sat_d | s1.sat;
        wr_d    = s1.val;
        state_d = S_M4;
      end
      S_M4: begin
        acc_d   = mul_p;
        state_d = S_M5;
      end
      S_M5: begin
        sat_d   = sat_d | s1.sat;
        wi_d    = s1.val;
        state_d = S_M6;
      end
      S_M6: begin
        s1      = clip((WORD_BITS+2)'(a_q) + (WORD_BITS+2)'(mul_p));
        sat_d   = sat_d | s1.sat;
        nr_d    = s1.val;
        state_d = S_DONE;
      end
      S_DONE: begin
        // wait here while an earlier result is still unread
        if (!out_valid_o || out_ready_i) begin
          x_d     = nr_q;
          y_d     = mul_p;
          zr_d    = nr_q;
          zi_d    = mul_p;
          zs_d    = sat_d;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      ov_q    <= 1'b0;
      a_q     <= A_RST;
      b_q     <= B_RST;
      k_q     <= K_RST;
      p_q     <= P_RST;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      y_q     <= y_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFFSET_A: a_q <= signed'(cfg_data_i);
          CFG_GAIN_B:   b_q <= signed'(cfg_data_i);
          CFG_PHASE_K:  k_q <= signed'(cfg_data_i);
          CFG_PHASE_P:  p_q <= signed'(cfg_data_i);
          default:      a_q <= a_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    dv_q    <= dv_d;
    quo_q   <= quo_d;
    r_q     <= r_d;
    thneg_q <= thneg_d;
    flip_q  <= flip_d;
    cnt_q   <= cnt_d;
    ang_q   <= ang_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    c_q     <= c_d;
    s_q     <= s_d;
    wr_q    <= wr_d;
    wi_q    <= wi_d;
    nr_q    <= nr_d;
    sat_q   <= sat_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    zs_q    <= zs_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign z_real_o    = zr_q;
  assign z_imag_o    = zi_q;
  assign saturated_o = zs_q;

endmodule

// ----- rtl/ikm_check.sv -----
`timescale 1ns / 1ps
// port-level checks of the ikeda map iterator, bound to the top level
module ikm_check (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 restart_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [ikm_pkg::WORD_BITS-1:0] z_real_o,
  input logic signed [ikm_pkg::WORD_BITS-1:0] z_imag_o,
  input logic                                 saturated_o,
  input logic                                 cfg_we_i,
  input logic [ikm_pkg::CFG_W-1:0]            cfg_idx_i,
  input logic [ikm_pkg::WORD_BITS-1:0]        cfg_data_i
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(z_real_o)
      && $stable(z_imag_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready again straight after an accept");

  // a new result does not rise straight after an accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result too early after accept");

  // a result only appears while the block is still busy finishing it
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised from idle");

endmodule

bind ikeda_map_iterator ikm_check u_ikm_check (.*);
